FILE: hw/rtl/bank_mapper_with_rtc_top_assert.svh
// Assertion macros for the bank mapper.
`ifndef BANK_MAPPER_WITH_RTC_TOP_ASSERT_SVH
`define BANK_MAPPER_WITH_RTC_TOP_ASSERT_SVH

// Condition must hold at every edge out of reset.
`define BMR_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("bank mapper invariant failed");

// Consequent must hold in the cycle after the antecedent.
`define BMR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bank mapper sequence check failed");

`endif

FILE: hw/rtl/bmr_pkg.sv
package bmr_pkg;

	typedef enum logic [1:0] {
		FN_READ  = 2'd0,
		FN_WRITE = 2'd1,
		FN_TICK  = 2'd2,
		FN_NONE  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		TGT_NONE   = 2'd0,
		TGT_ROM_RD = 2'd1,
		TGT_RAM_RD = 2'd2,
		TGT_RAM_WR = 2'd3
	} target_t;

	// Upper three address bits
	typedef enum logic [2:0] {
		RGN_ENABLE = 3'b000,
		RGN_BANK   = 3'b001,
		RGN_SELECT = 3'b010,
		RGN_LATCH  = 3'b011,
		RGN_EXTRAM = 3'b101
	} region_t;

	localparam logic [7:0] SEL_SEC     = 8'h08;
	localparam logic [7:0] SEL_MIN     = 8'h09;
	localparam logic [7:0] SEL_HOUR    = 8'h0A;
	localparam logic [7:0] SEL_DAY_LO  = 8'h0B;
	localparam logic [7:0] SEL_DAY_HI  = 8'h0C;
	localparam logic [7:0] SEL_RAM_MAX = 8'h03;

	localparam logic [3:0] RAM_EN_KEY  = 4'hA;
	localparam logic [7:0] OPEN_BUS    = 8'hFF;

	localparam int MAPPED_W = 21;

endpackage

FILE: hw/rtl/bank_mapper_with_rtc_top.sv
// Channel | Dir | tdata (low bit up)                    | tuser
// s_*     | in  | addr[15:0], wdata[23:16]              | func[1:0]
// m_*     | out | mapped_addr[20:0], rdata[28:21],      | target[1:0]
//         |     | ram_wdata[36:29], zero pad [39:37]    |
// One item per cycle sustained while the output is not stalled; an accepted item
// passes the input register, then decode and clock carry into the result register.
// Mapper and clock state update when an item moves into the result register,
// so the following item already sees it.
// A stalled output holds its item; input stalls only when both stages are full.
// Asynchronous reset: rom_bank 1, all other state 0, both stages empty.
module bank_mapper_with_rtc_top #(
	parameter int ROM_BANK_BITS = 7,
	parameter int RAM_BANKS     = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // addr[15:0], wdata[23:16]
	input  logic [1:0]  s_tuser,  // func[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // mapped_addr[20:0], rdata[28:21], ram_wdata[36:29]
	output logic [1:0]  m_tuser   // target[1:0]
);

	localparam logic [15:0] Q60_MUL = 16'd137;  // floor(x/60) = (x*137)>>13 for x<256
	localparam logic [15:0] Q24_MUL = 16'd171;  // floor(x/24) = (x*171)>>12 for x<256

	// input stage
	logic              valid_s1;
	bmr_pkg::func_t    func_s1;
	logic [15:0]       addr_s1;
	logic [7:0]        wdata_s1;

	// result stage
	logic              valid_q;
	bmr_pkg::target_t  target_q;
	logic [20:0]       maddr_q;
	logic [7:0]        rdata_q;
	logic [7:0]        ramw_q;

	// mapper and clock state
	logic [6:0] rom_bank_q;
	logic [7:0] ram_select_q;
	logic       ram_enable_q;
	logic [5:0] clock_seconds_q;
	logic [5:0] clock_minutes_q;
	logic [4:0] clock_hours_q;
	logic [8:0] clock_days_q;
	logic       clock_halted_q;

	logic adv_s1;
	logic out_free;

	assign out_free = !valid_q || m_tready;
	assign adv_s1   = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1  <= bmr_pkg::func_t'(s_tuser);
			addr_s1  <= s_tdata[15:0];
			wdata_s1 <= s_tdata[23:16];
		end
	end

	// decode
	bmr_pkg::region_t  region;
	logic              in_ram;
	logic              ram_ok;
	logic [20:0]       extram_map_addr;
	logic [20:0]       cart_map_addr;
	logic [7:0]        clk_rd;
	bmr_pkg::target_t  target_d;
	logic [20:0]       maddr_d;
	logic [7:0]        rdata_d;
	logic [7:0]        ramw_d;

	logic [15:0] q60_prod;
	logic [15:0] q24_prod;
	logic [7:0]  q60;
	logic [7:0]  q24;
	logic [5:0]  wr_mod60;
	logic [4:0]  wr_mod24;

	assign region   = bmr_pkg::region_t'(addr_s1[15:13]);
	assign in_ram   = (addr_s1[15:13] == bmr_pkg::RGN_EXTRAM) && ram_enable_q;
	assign ram_ok   = (ram_select_q <= bmr_pkg::SEL_RAM_MAX) &&
	                  (ram_select_q < 8'(RAM_BANKS));
	assign extram_map_addr = 21'({ram_select_q[1:0], addr_s1[12:0]});
	assign cart_map_addr   = (addr_s1[14] == 1'b0) ? 21'(addr_s1[13:0]) :
	                         21'({rom_bank_q[ROM_BANK_BITS-1:0], addr_s1[13:0]});

	assign q60_prod = 16'(wdata_s1) * Q60_MUL;
	assign q24_prod = 16'(wdata_s1) * Q24_MUL;
	assign q60      = 8'(q60_prod >> 13);
	assign q24      = 8'(q24_prod >> 12);
	assign wr_mod60 = 6'(wdata_s1 - 8'(q60 * 8'd60));
	assign wr_mod24 = 5'(wdata_s1 - 8'(q24 * 8'd24));

	always_comb begin
		clk_rd = bmr_pkg::OPEN_BUS;
		case (ram_select_q)
			bmr_pkg::SEL_SEC:    clk_rd = 8'(clock_seconds_q);
			bmr_pkg::SEL_MIN:    clk_rd = 8'(clock_minutes_q);
			bmr_pkg::SEL_HOUR:   clk_rd = 8'(clock_hours_q);
			bmr_pkg::SEL_DAY_LO: clk_rd = clock_days_q[7:0];
			bmr_pkg::SEL_DAY_HI: clk_rd = {1'b0, clock_halted_q, 5'd0, clock_days_q[8]};
			default:             clk_rd = bmr_pkg::OPEN_BUS;
		endcase
	end

	always_comb begin
		target_d = bmr_pkg::TGT_NONE;
		maddr_d  = '0;
		rdata_d  = '0;
		ramw_d   = '0;
		unique case (func_s1)
			bmr_pkg::FN_READ: begin
				if (addr_s1[15] == 1'b0) begin
					target_d = bmr_pkg::TGT_ROM_RD;
					maddr_d  = cart_map_addr;
				end else if (in_ram && ram_select_q <= bmr_pkg::SEL_RAM_MAX) begin
					if (ram_ok) begin
						target_d = bmr_pkg::TGT_RAM_RD;
						maddr_d  = extram_map_addr;
					end else begin
						rdata_d = bmr_pkg::OPEN_BUS;
					end
				end else if (in_ram) begin
					rdata_d = clk_rd;
				end else begin
					rdata_d = bmr_pkg::OPEN_BUS;
				end
			end
			bmr_pkg::FN_WRITE: begin
				if (in_ram && ram_ok) begin
					target_d = bmr_pkg::TGT_RAM_WR;
					maddr_d  = extram_map_addr;
					ramw_d   = wdata_s1;
				end
			end
			bmr_pkg::FN_TICK, bmr_pkg::FN_NONE: begin
			end
			default: begin
			end
		endcase
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bank_q      <= 7'd1;
			ram_select_q    <= '0;
			ram_enable_q    <= 1'b0;
			clock_seconds_q <= '0;
			clock_minutes_q <= '0;
			clock_hours_q   <= '0;
			clock_days_q    <= '0;
			clock_halted_q  <= 1'b0;
		end else if (adv_s1) begin
			if (func_s1 == bmr_pkg::FN_WRITE) begin
				case (region)
					bmr_pkg::RGN_ENABLE: ram_enable_q <= (wdata_s1[3:0] == bmr_pkg::RAM_EN_KEY);
					bmr_pkg::RGN_BANK:   rom_bank_q   <= (wdata_s1[6:0] == 7'd0) ? 7'd1 :
					                                     wdata_s1[6:0];
					bmr_pkg::RGN_SELECT: ram_select_q <= wdata_s1;
					bmr_pkg::RGN_EXTRAM: begin
						if (ram_enable_q) begin
							case (ram_select_q)
								bmr_pkg::SEL_SEC:    clock_seconds_q <= wr_mod60;
								bmr_pkg::SEL_MIN:    clock_minutes_q <= wr_mod60;
								bmr_pkg::SEL_HOUR:   clock_hours_q   <= wr_mod24;
								bmr_pkg::SEL_DAY_LO: clock_days_q[7:0] <= wdata_s1;
								bmr_pkg::SEL_DAY_HI: begin
									clock_days_q[8] <= wdata_s1[0];
									clock_halted_q  <= wdata_s1[6];
								end
								default: begin
								end
							endcase
						end
					end
					default: begin
					end
				endcase
			end else if (func_s1 == bmr_pkg::FN_TICK && !clock_halted_q) begin
				if (clock_seconds_q != 6'd59) begin
					clock_seconds_q <= clock_seconds_q + 6'd1;
				end else begin
					clock_seconds_q <= '0;
					if (clock_minutes_q != 6'd59) begin
						clock_minutes_q <= clock_minutes_q + 6'd1;
					end else begin
						clock_minutes_q <= '0;
						if (clock_hours_q != 5'd23) begin
							clock_hours_q <= clock_hours_q + 5'd1;
						end else begin
							clock_hours_q <= '0;
							clock_days_q  <= clock_days_q + 9'd1;
						end
					end
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			target_q <= target_d;
			maddr_q  <= maddr_d;
			rdata_q  <= rdata_d;
			ramw_q   <= ramw_d;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tuser  = target_q;
	assign m_tdata  = {3'd0, ramw_q, rdata_q, maddr_q};

`include "bank_mapper_with_rtc_top_assert.svh"

	`BMR_ASSERT_ALWAYS(a_bank_nonzero, rom_bank_q != 7'd0)
	`BMR_ASSERT_ALWAYS(a_clock_range,
		clock_seconds_q < 6'd60 && clock_minutes_q < 6'd60 && clock_hours_q < 5'd24)
	`BMR_ASSERT_ALWAYS(a_ramw_only_on_write,
		!valid_q || target_q == bmr_pkg::TGT_RAM_WR || ramw_q == 8'd0)
	`BMR_ASSERT_NEXT(a_halt_freezes,
		clock_halted_q && !(adv_s1 && func_s1 == bmr_pkg::FN_WRITE),
		$stable(clock_seconds_q) && $stable(clock_days_q))

endmodule

FILE: sim/tb_bank_mapper_with_rtc_top.sv
module tb_bank_mapper_with_rtc_top;

	typedef struct packed {
		bmr_pkg::target_t target;
		logic [20:0]      mapped_addr;
		logic [7:0]       rdata;
		logic [7:0]       ram_wdata;
	} bus_result_t;

	class mapper_scoreboard;
		localparam int ROM_BANK_BITS = 7;
		localparam int RAM_BANKS     = 4;
		localparam logic [6:0] BANK_MASK = 7'((1 << ROM_BANK_BITS) - 1);

		bus_result_t pending_results[$];
		int errors;
		int n_rom, n_ram_rd, n_ram_wr, n_none, n_ticks, n_day_wraps;

		logic [6:0] rom_bank;
		logic [7:0] ram_sel;
		logic       ram_en;
		logic [5:0] rtc_sec;
		logic [5:0] rtc_mins;
		logic [4:0] rtc_hour;
		logic [8:0] rtc_days;
		logic       rtc_halted;

		function new();
			rom_bank = 7'd1;
			ram_sel = '0;
			ram_en = 1'b0;
			rtc_sec = '0;
			rtc_mins = '0;
			rtc_hour = '0;
			rtc_days = '0;
			rtc_halted = 1'b0;
		endfunction

		task report(string msg);
			$display("MISMATCH @%0t: %s", $time, msg);
			errors++;
		endtask

		function void advance_clock();
			if (rtc_halted)
				return;
			if (rtc_sec != 6'd59) begin
				rtc_sec++;
				return;
			end
			rtc_sec = '0;
			if (rtc_mins != 6'd59) begin
				rtc_mins++;
				return;
			end
			rtc_mins = '0;
			if (rtc_hour != 5'd23) begin
				rtc_hour++;
				return;
			end
			rtc_hour = '0;
			if (rtc_days == 9'd511)
				n_day_wraps++;
			rtc_days = rtc_days + 9'd1;
		endfunction

		function void note_access(bmr_pkg::func_t fn, logic [15:0] addr, logic [7:0] wdata);
			bus_result_t r;
			logic in_ext;
			logic [6:0] b;
			r = '{bmr_pkg::TGT_NONE, 21'd0, 8'd0, 8'd0};
			in_ext = addr >= 16'hA000 && addr < 16'hC000;
			case (fn)
				bmr_pkg::FN_READ: begin
					r.rdata = bmr_pkg::OPEN_BUS;
					if (addr < 16'h4000) begin
						r.target = bmr_pkg::TGT_ROM_RD;
						r.mapped_addr = 21'(addr);
						r.rdata = '0;
					end else if (addr < 16'h8000) begin
						r.target = bmr_pkg::TGT_ROM_RD;
						r.mapped_addr = 21'(addr - 16'h4000)
							+ 21'(rom_bank & BANK_MASK) * 21'h4000;
						r.rdata = '0;
					end else if (in_ext && ram_en) begin
						if (ram_sel <= bmr_pkg::SEL_RAM_MAX) begin
							if (ram_sel < RAM_BANKS) begin
								r.target = bmr_pkg::TGT_RAM_RD;
								r.mapped_addr = 21'(addr - 16'hA000) + 21'(ram_sel) * 21'h2000;
								r.rdata = '0;
							end
						end else begin
							case (ram_sel)
								bmr_pkg::SEL_SEC:    r.rdata = 8'(rtc_sec);
								bmr_pkg::SEL_MIN:    r.rdata = 8'(rtc_mins);
								bmr_pkg::SEL_HOUR:   r.rdata = 8'(rtc_hour);
								bmr_pkg::SEL_DAY_LO: r.rdata = rtc_days[7:0];
								bmr_pkg::SEL_DAY_HI: r.rdata = {1'b0, rtc_halted, 5'b0, rtc_days[8]};
								default: ;
							endcase
						end
					end
				end
				bmr_pkg::FN_WRITE: begin
					if (addr < 16'h2000) begin
						ram_en = wdata[3:0] == bmr_pkg::RAM_EN_KEY;
					end else if (addr < 16'h4000) begin
						b = wdata[6:0];
						rom_bank = (b == 7'd0) ? 7'd1 : b;
					end else if (addr < 16'h6000) begin
						ram_sel = wdata;
					end else if (in_ext && ram_en) begin
						if (ram_sel <= bmr_pkg::SEL_RAM_MAX) begin
							if (ram_sel < RAM_BANKS) begin
								r.target = bmr_pkg::TGT_RAM_WR;
								r.mapped_addr = 21'(addr - 16'hA000) + 21'(ram_sel) * 21'h2000;
								r.ram_wdata = wdata;
							end
						end else begin
							case (ram_sel)
								bmr_pkg::SEL_SEC:    rtc_sec = 6'(wdata % 60);
								bmr_pkg::SEL_MIN:    rtc_mins = 6'(wdata % 60);
								bmr_pkg::SEL_HOUR:   rtc_hour = 5'(wdata % 24);
								bmr_pkg::SEL_DAY_LO: rtc_days[7:0] = wdata;
								bmr_pkg::SEL_DAY_HI: begin
									rtc_days[8] = wdata[0];
									rtc_halted = wdata[6];
								end
								default: ;
							endcase
						end
					end
				end
				bmr_pkg::FN_TICK: begin
					n_ticks++;
					advance_clock();
				end
				default: ;
			endcase
			pending_results.push_back(r);
		endfunction

		task check_result(logic [1:0] tuser, logic [39:0] tdata);
			bus_result_t e;
			if (pending_results.size() == 0) begin
				report($sformatf("result with no access pending: tuser=%0d tdata=%h", tuser, tdata));
				return;
			end
			e = pending_results.pop_front();
			case (e.target)
				bmr_pkg::TGT_ROM_RD: n_rom++;
				bmr_pkg::TGT_RAM_RD: n_ram_rd++;
				bmr_pkg::TGT_RAM_WR: n_ram_wr++;
				default:             n_none++;
			endcase
			if (tuser != e.target)
				report($sformatf("target %0d, want %0d", tuser, e.target));
			if (tdata[20:0] != e.mapped_addr)
				report($sformatf("mapped_addr %h, want %h", tdata[20:0], e.mapped_addr));
			if (tdata[28:21] != e.rdata)
				report($sformatf("rdata %h, want %h", tdata[28:21], e.rdata));
			if (tdata[36:29] != e.ram_wdata)
				report($sformatf("ram_wdata %h, want %h", tdata[36:29], e.ram_wdata));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;

	mapper_scoreboard sb;
	int items_sent;
	int burst_left;
	int stall_mode;
	int stall_left;
	int stall_phase;

	bank_mapper_with_rtc_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	initial begin
		#5000000;
		$display("bank_mapper_with_rtc_top test failed");
		$finish;
	end

	// receiver stall pattern, changes character every stretch
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(20, 120);
			stall_phase <= 0;
		end else begin
			stall_left <= stall_left - 1;
			stall_phase <= stall_phase + 1;
		end
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= $urandom_range(0, 1);
			2: m_tready <= (stall_phase % 4) == 0;
			default: m_tready <= (stall_phase % 9) >= 6;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tuser, m_tdata);
	end

	task automatic push(bmr_pkg::func_t fn, logic [15:0] addr, logic [7:0] wdata);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= fn;
		s_tdata <= {wdata, addr};
		do @(posedge clk); while (!s_tready);
		sb.note_access(fn, addr, wdata);
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(0, 15);
		end
	endtask

	// drive the clock to the edge of a rollover, tick a few times, read it all back
	task automatic clock_preset();
		logic [7:0] sel;
		logic [7:0] val;
		push(bmr_pkg::FN_WRITE, 16'($urandom_range(0, 16'h1FFF)),
			{4'($urandom), bmr_pkg::RAM_EN_KEY});
		for (int i = 0; i < 5; i++) begin
			sel = bmr_pkg::SEL_SEC + 8'(i);
			case (sel)
				bmr_pkg::SEL_SEC:    val = 8'($urandom_range(56, 59));
				bmr_pkg::SEL_MIN:    val = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'd59;
				bmr_pkg::SEL_HOUR:   val = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'd23;
				bmr_pkg::SEL_DAY_LO: val = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'hFF;
				default:             val = (8'($urandom) & 8'hBE) | 8'h01
					| (($urandom_range(0, 4) == 0) ? 8'h40 : 8'h00);
			endcase
			push(bmr_pkg::FN_WRITE, 16'h4000 | 16'($urandom_range(0, 16'h1FFF)), sel);
			push(bmr_pkg::FN_WRITE, 16'hA000 | 16'($urandom_range(0, 16'h1FFF)), val);
		end
		repeat ($urandom_range(1, 5))
			push(bmr_pkg::FN_TICK, 16'($urandom), 8'($urandom));
		for (int i = 0; i < 5; i++) begin
			push(bmr_pkg::FN_WRITE, 16'h4000 | 16'($urandom_range(0, 16'h1FFF)),
				bmr_pkg::SEL_SEC + 8'(i));
			push(bmr_pkg::FN_READ, 16'hA000 | 16'($urandom_range(0, 16'h1FFF)), 8'($urandom));
		end
	endtask

	initial begin
		int kind;
		int wait_cycles;
		logic [7:0] sel;
		sb = new();
		items_sent = 0;
		burst_left = 0;
		stall_mode = 0;
		stall_left = 0;
		stall_phase = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		push(bmr_pkg::FN_READ, 16'h0000, 8'h00);
		push(bmr_pkg::FN_READ, 16'h3FFF, 8'hFF);
		push(bmr_pkg::FN_READ, 16'h4000, 8'h00);
		push(bmr_pkg::FN_WRITE, 16'h2000, 8'h00);
		push(bmr_pkg::FN_READ, 16'h4000, 8'h00);
		push(bmr_pkg::FN_WRITE, 16'h3FFF, 8'hFF);
		push(bmr_pkg::FN_READ, 16'h7FFF, 8'h00);
		push(bmr_pkg::FN_READ, 16'hA000, 8'h00);
		push(bmr_pkg::FN_WRITE, 16'h1FFF, 8'hFA);
		push(bmr_pkg::FN_WRITE, 16'h4000, 8'h03);
		push(bmr_pkg::FN_WRITE, 16'hBFFF, 8'hFF);
		push(bmr_pkg::FN_READ, 16'hBFFF, 8'h00);
		push(bmr_pkg::FN_WRITE, 16'h5FFF, 8'h04);
		push(bmr_pkg::FN_READ, 16'hA000, 8'h00);
		push(bmr_pkg::FN_WRITE, 16'h4000, bmr_pkg::SEL_SEC);
		push(bmr_pkg::FN_WRITE, 16'hA000, 8'hFF);
		push(bmr_pkg::FN_TICK, 16'hFFFF, 8'hFF);
		push(bmr_pkg::FN_READ, 16'hA000, 8'h00);
		push(bmr_pkg::FN_WRITE, 16'h4000, bmr_pkg::SEL_DAY_HI);
		push(bmr_pkg::FN_WRITE, 16'hA000, 8'h41);
		push(bmr_pkg::FN_TICK, 16'h0000, 8'h00);
		push(bmr_pkg::FN_READ, 16'hA000, 8'h00);
		push(bmr_pkg::FN_WRITE, 16'h6000, 8'hFF);
		push(bmr_pkg::FN_WRITE, 16'h8000, 8'h55);
		push(bmr_pkg::FN_READ, 16'hFFFF, 8'h00);
		push(bmr_pkg::FN_NONE, 16'hFFFF, 8'hFF);
		push(bmr_pkg::FN_WRITE, 16'h4000, 8'h0D);
		push(bmr_pkg::FN_READ, 16'hA000, 8'h00);
		push(bmr_pkg::FN_WRITE, 16'h0000, 8'h00);

		while (items_sent < 1130) begin
			kind = $urandom_range(0, 99);
			if (kind < 20) begin
				push(bmr_pkg::FN_TICK, 16'($urandom), 8'($urandom));
			end else if (kind < 34) begin
				push(bmr_pkg::FN_READ, 16'($urandom_range(0, 16'h7FFF)), 8'($urandom));
			end else if (kind < 39) begin
				push(bmr_pkg::FN_WRITE, 16'h2000 | 16'($urandom_range(0, 16'h1FFF)),
					8'($urandom));
			end else if (kind < 44) begin
				push(bmr_pkg::FN_WRITE, 16'($urandom_range(0, 16'h1FFF)),
					($urandom_range(0, 9) < 7) ? {4'($urandom), bmr_pkg::RAM_EN_KEY}
					: 8'($urandom));
			end else if (kind < 52) begin
				case ($urandom_range(0, 2))
					0: sel = 8'($urandom_range(0, 3));
					1: sel = 8'($urandom_range(8, 12));
					default: sel = 8'($urandom);
				endcase
				push(bmr_pkg::FN_WRITE, 16'h4000 | 16'($urandom_range(0, 16'h1FFF)), sel);
			end else if (kind < 74) begin
				push($urandom_range(0, 1) ? bmr_pkg::FN_WRITE : bmr_pkg::FN_READ,
					16'hA000 | 16'($urandom_range(0, 16'h1FFF)), 8'($urandom));
			end else if (kind < 79) begin
				clock_preset();
			end else if (kind < 89) begin
				push(bmr_pkg::func_t'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
			end else if (kind < 94) begin
				push(bmr_pkg::FN_WRITE,
					$urandom_range(0, 1) ? 16'($urandom_range(16'h6000, 16'h9FFF))
					: 16'($urandom_range(16'hC000, 16'hFFFF)), 8'($urandom));
			end else begin
				repeat ($urandom_range(1, 70))
					push(bmr_pkg::FN_TICK, 16'($urandom), 8'($urandom));
			end
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		wait_cycles = 0;
		while (sb.pending_results.size() != 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (8) @(posedge clk);
		while (sb.pending_results.size() != 0) begin
			void'(sb.pending_results.pop_front());
			sb.report("expected result never arrived");
		end

		$display("covered %0d items: %0d ROM reads, %0d RAM reads, %0d RAM writes, %0d no-memory",
			items_sent, sb.n_rom, sb.n_ram_rd, sb.n_ram_wr, sb.n_none);
		$display("clock: %0d ticks, %0d day wraps; %0d mismatches",
			sb.n_ticks, sb.n_day_wraps, sb.errors);
		if (sb.errors == 0)
			$display("bank_mapper_with_rtc_top test passed");
		else
			$display("bank_mapper_with_rtc_top test failed");
		$finish;
	end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/bmr_pkg.sv
hw/rtl/bank_mapper_with_rtc_top.sv
sim/tb_bank_mapper_with_rtc_top.sv
